### src/mrc_pkg.sv
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types and constants of the Modbus RTU read-response checker.
// ----------------------------------------------------------------------------
package mrc_pkg;

	localparam int MAX_REGS = 64;
	localparam int WIDX_W   = $clog2(MAX_REGS);

	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [7:0]  FUNC_READ = 8'h03;
	localparam logic [7:0]  EXC_FLAG  = 8'h80;

	localparam logic REG_SLAVE_ADDR = 1'b0;
	localparam logic REG_EXP_REGS   = 1'b1;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_ADDR_ERR  = 3'd1,
		ST_EXCEPTION = 3'd2,
		ST_BAD_FUNC  = 3'd3,
		ST_COUNT_ERR = 3'd4,
		ST_CRC_ERR   = 3'd5,
		ST_TIMEOUT   = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		PH_DONE   = 4'd0,
		PH_ADDR   = 4'd1,
		PH_FUNC   = 4'd2,
		PH_COUNT  = 4'd3,
		PH_DATA   = 4'd4,
		PH_CRCLO  = 4'd5,
		PH_CRCHI  = 4'd6,
		PH_EXCODE = 4'd7,
		PH_XCRCLO = 4'd8,
		PH_XCRCHI = 4'd9
	} phase_t;

	typedef enum logic [1:0] {
		S_WAIT = 2'd0,
		S_CRC  = 2'd1,
		S_RD   = 2'd2,
		S_LD   = 2'd3
	} ctl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic crc_shift;
		logic rd_issue;
		logic load_word;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic upd_crc;
		logic emit;
		logic crc_last;
		logic last_word;
		logic out_busy;
	} dp_sts_t;

endpackage

### src/mrc_ctrl.sv
// ----------------------------------------------------------------------------
// mrc_ctrl
// Sequencer: takes items, runs the bit-serial CRC and walks the word buffer.
// ----------------------------------------------------------------------------
module mrc_ctrl
	import mrc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	ctl_state_t state_q;
	ctl_state_t state_nxt;
	logic       out_free;

	assign out_free = !sts.out_busy || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_WAIT;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_WAIT: begin
				if (in_valid && out_free) begin
					if (sts.upd_crc) begin
						state_nxt = S_CRC;
					end else if (sts.emit) begin
						state_nxt = S_RD;
					end
				end
			end
			S_CRC: begin
				if (sts.crc_last) begin
					state_nxt = S_WAIT;
				end
			end
			S_RD: begin
				state_nxt = S_LD;
			end
			S_LD: begin
				if (out_free) begin
					state_nxt = sts.last_word ? S_WAIT : S_RD;
				end
			end
			default: begin
				state_nxt = S_WAIT;
			end
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		cmd           = '0;
		case (state_q)
			S_WAIT: begin
				in_ready   = out_free;
				cmd.accept = in_valid && out_free;
			end
			S_CRC: begin
				cmd.crc_shift = 1'b1;
			end
			S_RD: begin
				cmd.rd_issue = 1'b1;
			end
			S_LD: begin
				cmd.load_word = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

### src/mrc_dp.sv
// ----------------------------------------------------------------------------
// mrc_dp
// Datapath: frame parsing, running CRC, word buffer and the output register.
// ----------------------------------------------------------------------------
module mrc_dp
	import mrc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_sts_t           sts,
	input  logic              in_cmd,
	input  logic [7:0]        in_byte,
	input  logic [7:0]        slave_address,
	input  logic [6:0]        expected_regs,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [2:0]        out_status,
	output logic [15:0]       out_word,
	output logic [WIDX_W-1:0] out_index,
	output logic              out_last
);

	phase_t            phase_q;
	logic [15:0]       crc_q;
	logic [7:0]        cnt_q;
	logic [7:0]        high_q;
	logic [7:0]        crc_lo_q;
	logic [7:0]        exc_q;
	logic [6:0]        frame_regs_q;
	logic [2:0]        bit_cnt_q;
	logic [WIDX_W-1:0] rd_idx_q;
	logic [15:0]       rdata_q;
	logic [15:0]       mem [MAX_REGS];

	// Decisions taken on the item being accepted.
	phase_t      phase_nxt;
	logic        res_load;
	status_t     res_status;
	logic [15:0] res_word;
	logic        upd_crc;
	logic        emit;
	logic        count_bad;
	logic        crc_match;
	logic [7:0]  cnt_inc;
	logic        wr_word;

	assign cnt_inc   = cnt_q + 8'd1;
	assign crc_match = ({in_byte, crc_lo_q} == crc_q);
	assign count_bad = (expected_regs == 7'd0) || (expected_regs > 7'(MAX_REGS)) ||
		(in_byte != {expected_regs[6:0], 1'b0});
	assign wr_word   = cmd.accept && !in_cmd && (phase_q == PH_DATA) && cnt_q[0];

	always_comb begin
		phase_nxt  = phase_q;
		res_load   = 1'b0;
		res_status = ST_OK;
		res_word   = 16'h0000;
		upd_crc    = 1'b0;
		emit       = 1'b0;
		if (in_cmd) begin
			phase_nxt  = PH_ADDR;
			res_load   = (phase_q != PH_DONE);
			res_status = ST_TIMEOUT;
		end else begin
			case (phase_q)
				PH_ADDR: begin
					if (in_byte != slave_address) begin
						phase_nxt  = PH_DONE;
						res_load   = 1'b1;
						res_status = ST_ADDR_ERR;
					end else begin
						upd_crc   = 1'b1;
						phase_nxt = PH_FUNC;
					end
				end
				PH_FUNC: begin
					upd_crc = 1'b1;
					if (in_byte == (FUNC_READ | EXC_FLAG)) begin
						phase_nxt = PH_EXCODE;
					end else if (in_byte == FUNC_READ) begin
						phase_nxt = PH_COUNT;
					end else begin
						phase_nxt  = PH_DONE;
						res_load   = 1'b1;
						res_status = ST_BAD_FUNC;
					end
				end
				PH_COUNT: begin
					if (count_bad) begin
						phase_nxt  = PH_DONE;
						res_load   = 1'b1;
						res_status = ST_COUNT_ERR;
					end else begin
						upd_crc   = 1'b1;
						phase_nxt = PH_DATA;
					end
				end
				PH_DATA: begin
					upd_crc = 1'b1;
					if (cnt_inc >= {frame_regs_q, 1'b0}) begin
						phase_nxt = PH_CRCLO;
					end
				end
				PH_CRCLO: begin
					phase_nxt = PH_CRCHI;
				end
				PH_CRCHI: begin
					phase_nxt = PH_DONE;
					if (!crc_match) begin
						res_load   = 1'b1;
						res_status = ST_CRC_ERR;
					end else begin
						emit = 1'b1;
					end
				end
				PH_EXCODE: begin
					upd_crc   = 1'b1;
					phase_nxt = PH_XCRCLO;
				end
				PH_XCRCLO: begin
					phase_nxt = PH_XCRCHI;
				end
				PH_XCRCHI: begin
					phase_nxt = PH_DONE;
					res_load  = 1'b1;
					if (!crc_match) begin
						res_status = ST_CRC_ERR;
					end else begin
						res_status = ST_EXCEPTION;
						res_word   = {8'h00, exc_q};
					end
				end
				default: begin
					phase_nxt = PH_DONE;
				end
			endcase
		end
	end

	assign sts.upd_crc   = upd_crc && !in_cmd;
	assign sts.emit      = emit;
	assign sts.crc_last  = (bit_cnt_q == 3'd7);
	assign sts.last_word = ({1'b0, rd_idx_q} + 7'd1 == frame_regs_q);
	assign sts.out_busy  = out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_DONE;
			crc_q        <= CRC_INIT;
			cnt_q        <= 8'd0;
			high_q       <= 8'd0;
			crc_lo_q     <= 8'd0;
			exc_q        <= 8'd0;
			frame_regs_q <= 7'd0;
			bit_cnt_q    <= 3'd0;
			rd_idx_q     <= '0;
		end else begin
			if (cmd.accept) begin
				phase_q   <= phase_nxt;
				bit_cnt_q <= 3'd0;
				if (in_cmd) begin
					crc_q        <= CRC_INIT;
					cnt_q        <= 8'd0;
					high_q       <= 8'd0;
					crc_lo_q     <= 8'd0;
					exc_q        <= 8'd0;
					frame_regs_q <= 7'd0;
				end else begin
					if (upd_crc) begin
						crc_q <= crc_q ^ {8'h00, in_byte};
					end
					case (phase_q)
						PH_COUNT: begin
							if (!count_bad) begin
								frame_regs_q <= expected_regs;
								cnt_q        <= 8'd0;
							end
						end
						PH_DATA: begin
							cnt_q <= cnt_inc;
							if (!cnt_q[0]) begin
								high_q <= in_byte;
							end
						end
						PH_CRCLO, PH_XCRCLO: begin
							crc_lo_q <= in_byte;
						end
						PH_EXCODE: begin
							exc_q <= in_byte;
						end
						default: begin
							cnt_q <= cnt_q;
						end
					endcase
				end
				if (emit) begin
					rd_idx_q <= '0;
				end
			end
			// One polynomial step per cycle; eight steps finish the byte.
			if (cmd.crc_shift) begin
				crc_q     <= crc_q[0] ? ((crc_q >> 1) ^ CRC_POLY) : (crc_q >> 1);
				bit_cnt_q <= bit_cnt_q + 3'd1;
			end
			if (cmd.load_word) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_word) begin
			mem[cnt_q[WIDX_W:1]] <= {high_q, in_byte};
		end
		if (cmd.rd_issue) begin
			rdata_q <= mem[rd_idx_q];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if ((cmd.accept && res_load) || cmd.load_word) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && res_load) begin
			out_status <= res_status;
			out_word   <= res_word;
			out_index  <= '0;
			out_last   <= 1'b1;
		end else if (cmd.load_word) begin
			out_status <= ST_OK;
			out_word   <= rdata_q;
			out_index  <= rd_idx_q;
			out_last   <= sts.last_word;
		end
	end

endmodule

### src/modbus_rtu_read_response_checker.sv
// ----------------------------------------------------------------------------
// modbus_rtu_read_response_checker
// Byte-wise checker for Modbus RTU read-holding-registers replies.
// ----------------------------------------------------------------------------
// Each received byte is one item on the slave stream (tuser = 0); an item
// with tuser = 1 arms the checker for a new reply and reports a timeout if
// a reply was in progress. A byte that enters the CRC holds the block until
// its bit-serial CRC-16 update ends; other bytes free it at once. After a
// good CRC the buffered words leave one by one through a registered read of
// the 64-entry word buffer; no byte is taken until the last word, which
// carries tlast, is loaded. Any failure gives a single status item with
// tlast set. Items are accepted only while waiting, with the output register
// empty or being taken. Configuration: slave_address at 0x0, expected_regs at
// 0x4, written only while the checker is idle: a user rule, not enforced.
// ----------------------------------------------------------------------------
module modbus_rtu_read_response_checker
	import mrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Slave stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] cmd
	// Master stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [2:0] status, [18:3] reg_word, [24:19] word_index
	output logic        m_tlast,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0]        slave_address_q;
	logic [6:0]        expected_regs_q;
	dp_cmd_t           cmd;
	dp_sts_t           sts;
	logic [2:0]        out_status;
	logic [15:0]       out_word;
	logic [WIDX_W-1:0] out_index;
	logic              reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q <= 8'd1;
			expected_regs_q <= 7'd32;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_sel)
				REG_SLAVE_ADDR: slave_address_q <= pwdata[7:0];
				REG_EXP_REGS:   expected_regs_q <= pwdata[6:0];
				default:        slave_address_q <= slave_address_q;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_SLAVE_ADDR: prdata = {24'd0, slave_address_q};
			REG_EXP_REGS:   prdata = {25'd0, expected_regs_q};
			default:        prdata = 32'd0;
		endcase
	end

	mrc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mrc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_cmd        (s_tuser),
		.in_byte       (s_tdata),
		.slave_address (slave_address_q),
		.expected_regs (expected_regs_q),
		.out_ready     (m_tready),
		.out_valid     (m_tvalid),
		.out_status    (out_status),
		.out_word      (out_word),
		.out_index     (out_index),
		.out_last      (m_tlast)
	);

	assign m_tdata = {7'd0, out_index, out_word, out_status};

endmodule
